@@ rtl/core/qrbm_pkg.sv @@
// ----------------------------------------------------------------------------
// qrbm_pkg
// Shared types and constants of the quadrature rate and button monitor:
// sequencer states, result kinds, transition codes and the step decoder.
// ----------------------------------------------------------------------------
package qrbm_pkg;

	// Fixed field widths
	localparam int RATE_W  = 16;
	localparam int KIND_W  = 2;
	localparam int NOW_W   = 32;
	localparam int MIND_W  = 16;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam int SCALE_W = 20;

	// Rate scale: microseconds per second
	localparam logic [SCALE_W-1:0] RATE_SCALE = SCALE_W'(1000000);

	// Register word index
	localparam logic REG_MIN_DELTA = 1'b0;

	// Item command codes
	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_RATE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DOWN = 2'd1;
	localparam logic [KIND_W-1:0] KIND_UP   = 2'd2;

	// Transition codes {new AB, previous AB}
	localparam logic [3:0] TR_UP_0 = 4'b0010;
	localparam logic [3:0] TR_UP_1 = 4'b0100;
	localparam logic [3:0] TR_UP_2 = 4'b1011;
	localparam logic [3:0] TR_UP_3 = 4'b1101;
	localparam logic [3:0] TR_DN_0 = 4'b0001;
	localparam logic [3:0] TR_DN_1 = 4'b0111;
	localparam logic [3:0] TR_DN_2 = 4'b1000;
	localparam logic [3:0] TR_DN_3 = 4'b1110;

	typedef enum logic [1:0] {
		DIR_NONE,
		DIR_UP,
		DIR_DOWN
	} dir_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_RATE,
		ST_BTN
	} state_t;

	// Decode one AB transition into a step direction
	function automatic dir_t decode_step(input logic [3:0] code);
		dir_t dir;
		case (code)
			TR_UP_0, TR_UP_1, TR_UP_2, TR_UP_3: dir = DIR_UP;
			TR_DN_0, TR_DN_1, TR_DN_2, TR_DN_3: dir = DIR_DOWN;
			default: dir = DIR_NONE;
		endcase
		return dir;
	endfunction

endpackage

@@ rtl/core/qrbm_if.sv @@
// ----------------------------------------------------------------------------
// qrbm_in_if / qrbm_out_if
// Valid/ready channels of the monitor: input items and result items.
// ----------------------------------------------------------------------------
interface qrbm_in_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic        a_level;
	logic        b_level;
	logic        switch_level;
	logic [31:0] now_us;

	modport source (output valid, cmd, a_level, b_level, switch_level, now_us,
		input ready);
	modport sink (input valid, cmd, a_level, b_level, switch_level, now_us,
		output ready);
endinterface

interface qrbm_out_if;
	logic               valid;
	logic               ready;
	logic [1:0]         event_kind;
	logic signed [15:0] rate;
	logic               last;

	modport source (output valid, event_kind, rate, last, input ready);
	modport sink (input valid, event_kind, rate, last, output ready);
endinterface

@@ rtl/core/qrbm_div.sv @@
// ----------------------------------------------------------------------------
// qrbm_div
// Restoring serial divider: one quotient bit per cycle through a single
// shared subtractor; keeps the low RATE_W quotient bits.
// ----------------------------------------------------------------------------
module qrbm_div
	import qrbm_pkg::*;
#(
	parameter int DVD_W = 36,
	parameter int DVS_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [RATE_W-1:0] quot
);

	localparam int CNT_W = $clog2(DVD_W + 1);

	logic [DVS_W-1:0]  rem_q;
	logic [DVD_W-1:0]  dvd_q;
	logic [DVS_W-1:0]  dvs_q;
	logic [RATE_W-1:0] quo_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DVS_W:0]    shifted;
	logic [DVS_W:0]    diff;

	// Trial subtract of the divisor from the shifted partial remainder
	always_comb begin
		shifted = {rem_q, dvd_q[DVD_W-1]};
		diff    = shifted - {1'b0, dvs_q};
	end

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: load operands, then shift one bit per step
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
			if (!diff[DVS_W]) begin
				rem_q <= diff[DVS_W-1:0];
				quo_q <= {quo_q[RATE_W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DVS_W-1:0];
				quo_q <= {quo_q[RATE_W-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;

endmodule

@@ rtl/core/quadrature_rate_button_monitor_core.sv @@
// A pin sample is absorbed in the cycle it is accepted.
// A tick without a rate report passes ST_EVAL and then shows its button item in ST_BTN.
// A tick with a rate report passes ST_EVAL and ST_DIV and shows it in ST_RATE,
// with the rate worked out by the one-bit-per-cycle serial divider.
// One item at a time; input is taken again once all results of a tick are out.
// Reset (arst_n, async, low) clears counts, last report time, button state; min_delta = 1.
// ----------------------------------------------------------------------------
// quadrature_rate_button_monitor_core
// Quadrature decoder with saturating step count, rate reports on ticks
// (steps * 1e6 / elapsed us through a serial divider) and button events.
// ----------------------------------------------------------------------------
module quadrature_rate_button_monitor_core
	import qrbm_pkg::*;
#(
	parameter int COUNT_WIDTH = 16,
	parameter int TIME_WIDTH  = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	qrbm_in_if.sink           in_ch,
	qrbm_out_if.source        out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	localparam int DVD_W = COUNT_WIDTH + SCALE_W;
	localparam int CMP_W = (COUNT_WIDTH > MIND_W) ? COUNT_WIDTH : MIND_W;
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};

	state_t state_q, state_d;

	logic [MIND_W-1:0]             min_delta_q;
	logic [1:0]                    prev_ab_q;
	logic signed [COUNT_WIDTH-1:0] step_count_q;
	logic [TIME_WIDTH-1:0]         last_time_q;
	logic [TIME_WIDTH-1:0]         now_q;
	logic [TIME_WIDTH-1:0]         elapsed_q;
	logic                          btn_now_q;
	logic                          btn_rep_q;
	logic                          neg_q;
	logic [RATE_W-1:0]             rate_q;

	logic                   in_take;
	logic                   out_take;
	logic                   cfg_wr;
	logic [1:0]             ab_new;
	dir_t                   dir;
	logic                   neg;
	logic [COUNT_WIDTH-1:0] mag;
	logic                   report;
	logic                   btn_diff;
	logic [TIME_WIDTH-1:0]  now_ext;
	logic [TIME_WIDTH-1:0]  elapsed_raw;
	logic [DVD_W-1:0]       product;
	logic                   div_start;
	logic                   div_done;
	logic [RATE_W-1:0]      div_quot;

	assign in_take  = in_ch.valid && in_ch.ready;
	assign out_take = out_ch.valid && out_ch.ready;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// Configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MIN_DELTA) ? APB_DW'(min_delta_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_delta_q <= MIND_W'(1);
		end else if (cfg_wr && paddr[2] == REG_MIN_DELTA) begin
			min_delta_q <= pwdata[MIND_W-1:0];
		end
	end

	// Step decode and report evaluation
	always_comb begin
		ab_new      = {in_ch.a_level, in_ch.b_level};
		dir         = decode_step({ab_new, prev_ab_q});
		neg         = step_count_q[COUNT_WIDTH-1];
		mag         = neg ? (COUNT_WIDTH'(0) - COUNT_WIDTH'(step_count_q))
			: COUNT_WIDTH'(step_count_q);
		report      = CMP_W'(mag) >= CMP_W'(min_delta_q);
		btn_diff    = btn_now_q != btn_rep_q;
		now_ext     = TIME_WIDTH'(in_ch.now_us);
		elapsed_raw = now_ext - last_time_q;
		product     = DVD_W'(mag) * DVD_W'(RATE_SCALE);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_take && in_ch.cmd == CMD_TICK) state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (report) state_d = ST_DIV;
				else if (btn_diff) state_d = ST_BTN;
				else state_d = ST_IDLE;
			end
			ST_DIV: begin
				if (div_done) state_d = ST_RATE;
			end
			ST_RATE: begin
				if (out_take) state_d = btn_diff ? ST_BTN : ST_IDLE;
			end
			ST_BTN: begin
				if (out_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ch.ready       = 1'b0;
		out_ch.valid      = 1'b0;
		out_ch.event_kind = KIND_RATE;
		out_ch.rate       = '0;
		out_ch.last       = 1'b1;
		div_start         = 1'b0;
		case (state_q)
			ST_IDLE: in_ch.ready = 1'b1;
			ST_EVAL: div_start = report;
			ST_RATE: begin
				out_ch.valid = 1'b1;
				out_ch.rate  = rate_q;
				out_ch.last  = !btn_diff;
			end
			ST_BTN: begin
				out_ch.valid      = 1'b1;
				out_ch.event_kind = btn_now_q ? KIND_DOWN : KIND_UP;
			end
			default: ;
		endcase
	end

	// Control and monitor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			prev_ab_q    <= '0;
			step_count_q <= '0;
			last_time_q  <= '0;
			btn_now_q    <= 1'b0;
			btn_rep_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			// Absorb a pin sample
			if (in_take && in_ch.cmd == CMD_SAMPLE) begin
				prev_ab_q <= ab_new;
				btn_now_q <= !in_ch.switch_level;
				if (dir == DIR_UP && step_count_q != CNT_MAX)
					step_count_q <= step_count_q + COUNT_WIDTH'(1);
				else if (dir == DIR_DOWN && step_count_q != CNT_MIN)
					step_count_q <= step_count_q - COUNT_WIDTH'(1);
			end
			// Restart the interval once the rate item is taken
			if (state_q == ST_RATE && out_take) begin
				step_count_q <= '0;
				last_time_q  <= now_q;
			end
			if (state_q == ST_BTN && out_take) btn_rep_q <= btn_now_q;
		end
	end

	// Tick payload: timestamp, elapsed time, sign and rate
	always_ff @(posedge clk) begin
		if (in_take && in_ch.cmd == CMD_TICK) begin
			now_q     <= now_ext;
			elapsed_q <= (elapsed_raw == '0) ? TIME_WIDTH'(1) : elapsed_raw;
		end
		if (state_q == ST_EVAL) neg_q <= neg;
		if (div_done) rate_q <= neg_q ? (RATE_W'(0) - div_quot) : div_quot;
	end

	qrbm_div #(
		.DVD_W(DVD_W),
		.DVS_W(TIME_WIDTH)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(product),
		.divisor (elapsed_q),
		.done    (div_done),
		.quot    (div_quot)
	);

`ifndef ASSERT_OFF
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide phase");

	a_btn_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.event_kind != KIND_RATE) |-> out_ch.last)
		else $error("button item not marked last");

	a_rate_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && out_ch.event_kind == KIND_RATE) |=> step_count_q == '0)
		else $error("step count not cleared after rate item");

	a_btn_synced: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && out_ch.event_kind != KIND_RATE) |=> btn_rep_q == btn_now_q)
		else $error("reported button state not updated");

	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("input taken while a result is pending");
`endif

endmodule

@@ sim/quadrature_rate_button_monitor_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadrature_rate_button_monitor_core_tb
// Drives pin samples and report ticks into the monitor under random bursts,
// gaps and output stalls. A built-in decoder model predicts the rate and
// button items, which are checked in order as they leave the block.
// ----------------------------------------------------------------------------
module quadrature_rate_button_monitor_core_tb;
	import qrbm_pkg::*;

	localparam real CLK_HALF = 6.0;
	localparam int RESET_CYCLES = 9;
	// Drain time after the last item, longer than the longest tick through the divider
	localparam int SETTLE_CYCLES = 64;
	// Hang guard for ~2200 items plus settles and long stalls
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int PHASE_ITEMS = 220;
	localparam logic [63:0] US_PER_SEC = 64'd1000000;
	localparam logic signed [15:0] STEP_MAX = 16'sh7FFF;
	localparam logic signed [15:0] STEP_MIN = 16'sh8000;

	typedef struct packed {
		logic        cmd;
		logic        a_level;
		logic        b_level;
		logic        switch_level;
		logic [31:0] now_us;
	} pin_item_t;

	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [RATE_W-1:0] rate;
		logic                     is_last;
	} monitor_event_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic pready;

	qrbm_in_if in_ch ();
	qrbm_out_if out_ch ();

	quadrature_rate_button_monitor_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Pending input items and the events they are expected to cause
	pin_item_t pin_items[$];
	monitor_event_t expected_events[$];
	int unsigned errors;
	int unsigned cycles;

	// Decoder model state
	logic [15:0]        min_delta_cfg;
	logic [1:0]         model_prev_ab;
	logic signed [15:0] model_steps;
	logic [31:0]        model_report_time;
	logic               model_btn_now;
	logic               model_btn_reported;

	// Stimulus generator position
	logic [1:0]  gen_pos;
	logic        gen_sw;
	logic [31:0] gen_time;
	logic        gen_dir;

	// Sender and receiver pacing
	int  burst_left;
	int  gap_left;
	int  rx_mode;
	int  rx_mode_left;
	int  hold_left;
	bit  stall_req;

	// Clock
	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Work out the events one accepted item causes and update the model
	function automatic void predict_events(input pin_item_t it);
		logic [1:0]     ab;
		logic [3:0]     code;
		logic           neg;
		logic [16:0]    mag;
		logic [31:0]    elapsed;
		logic [63:0]    quot;
		logic [15:0]    rate16;
		int             n;
		monitor_event_t ev;
		n = 0;
		if (it.cmd == CMD_SAMPLE) begin
			ab = {it.a_level, it.b_level};
			code = {ab, model_prev_ab};
			case (code)
				TR_UP_0, TR_UP_1, TR_UP_2, TR_UP_3: begin
					if (model_steps != STEP_MAX)
						model_steps = model_steps + 16'sd1;
				end
				TR_DN_0, TR_DN_1, TR_DN_2, TR_DN_3: begin
					if (model_steps != STEP_MIN)
						model_steps = model_steps - 16'sd1;
				end
				default: ;
			endcase
			model_prev_ab = ab;
			model_btn_now = ~it.switch_level;
			return;
		end
		// Rate report when the count is large enough
		neg = model_steps[15];
		mag = neg ? (17'd0 - {1'b1, model_steps}) : {1'b0, model_steps};
		if (mag >= {1'b0, min_delta_cfg}) begin
			elapsed = it.now_us - model_report_time;
			if (elapsed == 32'd0)
				elapsed = 32'd1;
			quot = (64'(mag) * US_PER_SEC) / 64'(elapsed);
			rate16 = neg ? (16'd0 - quot[15:0]) : quot[15:0];
			ev.kind = KIND_RATE;
			ev.rate = rate16;
			ev.is_last = 1'b0;
			expected_events.push_back(ev);
			n++;
			model_steps = 16'sd0;
			model_report_time = it.now_us;
		end
		// Button event when the state moved since the last report
		if (model_btn_now != model_btn_reported) begin
			ev.kind = model_btn_now ? KIND_DOWN : KIND_UP;
			ev.rate = 16'sd0;
			ev.is_last = 1'b0;
			expected_events.push_back(ev);
			n++;
			model_btn_reported = model_btn_now;
		end
		if (n > 0)
			expected_events[expected_events.size() - 1].is_last = 1'b1;
	endfunction

	// Queue a pin sample and track where the encoder now sits
	function automatic void add_sample(input logic a, input logic b, input logic sw);
		pin_item_t it;
		it.cmd = CMD_SAMPLE;
		it.a_level = a;
		it.b_level = b;
		it.switch_level = sw;
		it.now_us = $urandom();
		pin_items.push_back(it);
		gen_pos = {a, a ^ b};
		gen_sw = sw;
	endfunction

	// Queue one valid step; up raises the step count
	function automatic void add_step(input logic up);
		logic [1:0] p;
		p = up ? gen_pos + 2'd1 : gen_pos - 2'd1;
		add_sample(p[1], p[1] ^ p[0], gen_sw);
	endfunction

	function automatic void add_tick(input logic [31:0] t);
		pin_item_t it;
		it.cmd = CMD_TICK;
		it.a_level = 1'($urandom_range(0, 1));
		it.b_level = 1'($urandom_range(0, 1));
		it.switch_level = 1'($urandom_range(0, 1));
		it.now_us = t;
		pin_items.push_back(it);
		gen_time = t;
	endfunction

	// One random item: mostly encoder walks, some ticks, switch moves and noise
	function automatic void add_random_item();
		int r;
		int m;
		logic [31:0] t;
		r = $urandom_range(0, 99);
		if (r < 9) begin
			m = $urandom_range(0, 9);
			t = gen_time;
			if (m == 1)
				t = $urandom();
			else if (m < 4 && m != 0)
				t = t + $urandom_range(1, 20);
			else if (m >= 4 && m < 8)
				t = t + $urandom_range(21, 5000);
			else if (m >= 8)
				t = t + $urandom_range(5001, 3000000);
			add_tick(t);
		end else if (r < 13) begin
			add_sample(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), gen_sw);
		end else if (r < 17) begin
			add_sample(gen_pos[1], gen_pos[1] ^ gen_pos[0], ~gen_sw);
		end else begin
			if ($urandom_range(0, 19) == 0)
				gen_dir = ~gen_dir;
			add_step(gen_dir);
		end
	endfunction

	// Sender: offer items in bursts, hold each until it is taken
	always @(posedge clk) begin
		logic offer;
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			offer = in_ch.valid;
			if (in_ch.valid && in_ch.ready) begin
				predict_events(pin_items.pop_front());
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pin_items.size() > 0) begin
					offer = 1'b1;
					in_ch.cmd <= pin_items[0].cmd;
					in_ch.a_level <= pin_items[0].a_level;
					in_ch.b_level <= pin_items[0].b_level;
					in_ch.switch_level <= pin_items[0].switch_level;
					in_ch.now_us <= pin_items[0].now_us;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 30);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1, 2: gap_left = $urandom_range(1, 3);
							default: gap_left = $urandom_range(4, 12);
						endcase
					end
				end
			end
			in_ch.valid <= offer;
		end
	end

	// Receiver: stall on its own pattern, with long hold-offs on request
	always @(posedge clk) begin
		logic rdy;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (hold_left == 0 && stall_req) begin
				stall_req = 1'b0;
				hold_left = $urandom_range(300, 500);
			end
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(50, 200);
			end else begin
				rx_mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				case (rx_mode)
					0: rdy = 1'b1;
					1: rdy = 1'($urandom_range(0, 1));
					default: rdy = ($urandom_range(0, 4) == 0);
				endcase
			end
			out_ch.ready <= rdy;
		end
	end

	// Check each result item against the oldest expectation
	always @(posedge clk) begin
		monitor_event_t exp_ev;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_events.size() == 0) begin
				$display("%0t: unexpected item kind %0d rate %0d last %0d", $time,
					out_ch.event_kind, out_ch.rate, out_ch.last);
				errors++;
			end else begin
				exp_ev = expected_events.pop_front();
				if (out_ch.event_kind !== exp_ev.kind) begin
					$display("%0t: event_kind expected %0d actual %0d", $time,
						exp_ev.kind, out_ch.event_kind);
					errors++;
				end
				if (out_ch.rate !== exp_ev.rate) begin
					$display("%0t: rate expected %0d actual %0d", $time,
						exp_ev.rate, out_ch.rate);
					errors++;
				end
				if (out_ch.last !== exp_ev.is_last) begin
					$display("%0t: last expected %0d actual %0d", $time,
						exp_ev.is_last, out_ch.last);
					errors++;
				end
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("quadrature_rate_button_monitor_core_tb: FAIL");
			$finish;
		end
	end

	task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr[APB_AW-1:2] == REG_MIN_DELTA)
			min_delta_cfg = data[15:0];
	endtask

	// Read min_delta back and compare with the model
	task automatic check_min_delta();
		logic [APB_DW-1:0] data;
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= {REG_MIN_DELTA, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		data = prdata;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (data !== {16'd0, min_delta_cfg}) begin
			$display("%0t: min_delta read expected %0d actual %0d", $time,
				min_delta_cfg, data);
			errors++;
		end
	endtask

	// Wait until every item is taken and every event is out, then let the block drain
	task automatic settle();
		while (pin_items.size() != 0 || in_ch.valid || expected_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_min_delta(input logic [15:0] md);
		settle();
		reg_write({REG_MIN_DELTA, 2'b00}, {16'($urandom()), md});
		check_min_delta();
	endtask

	initial begin
		logic [15:0] md;
		// Known values on every input from the start
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_SAMPLE;
		in_ch.a_level = 1'b0;
		in_ch.b_level = 1'b0;
		in_ch.switch_level = 1'b1;
		in_ch.now_us = '0;
		out_ch.ready = 1'b0;
		errors = 0;
		cycles = 0;
		burst_left = 0;
		gap_left = 0;
		rx_mode = 0;
		rx_mode_left = 0;
		hold_left = 0;
		stall_req = 1'b0;
		min_delta_cfg = 16'd1;
		model_prev_ab = 2'b00;
		model_steps = 16'sd0;
		model_report_time = '0;
		model_btn_now = 1'b0;
		model_btn_reported = 1'b0;
		gen_pos = 2'd0;
		gen_sw = 1'b1;
		gen_time = '0;
		gen_dir = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		check_min_delta();

		// Directed: quiet tick, press, four down steps, release, zero elapsed time
		add_tick(32'd0);
		add_sample(1'b0, 1'b0, 1'b0);
		add_tick(32'd0);
		repeat (4) add_step(1'b0);
		add_sample(1'b0, 1'b0, 1'b1);
		add_tick(32'd0);
		// Four up steps, skipped states, then a huge elapsed time
		repeat (4) add_step(1'b1);
		add_sample(1'b1, 1'b1, 1'b1);
		add_sample(1'b0, 1'b0, 1'b1);
		add_sample(1'b0, 1'b1, 1'b1);
		add_sample(1'b1, 1'b0, 1'b1);
		add_tick(32'hFFFF_FFFF);
		// Timestamp wrap, then a press with nothing to report
		add_step(1'b1);
		add_tick(32'd3);
		add_sample(gen_pos[1], gen_pos[1] ^ gen_pos[0], 1'b0);
		add_tick(32'd3);

		// Write outside the register map is dropped
		settle();
		reg_write(3'd4, 32'd0);
		check_min_delta();
		// Zero threshold reports even a zero count
		set_min_delta(16'd0);
		add_tick(32'd3);
		add_sample(gen_pos[1], gen_pos[1] ^ gen_pos[0], 1'b1);
		add_tick(32'd1003);

		// Build a large count under a high threshold, then report it
		set_min_delta(16'hFFFF);
		repeat (200) add_step(1'b1);
		add_tick(gen_time + 32'd50);
		set_min_delta(16'd200);
		add_tick(gen_time + 32'd1000);
		// Large negative count with a press, then a report one microsecond after that tick
		set_min_delta(16'hFFFF);
		repeat (200) add_step(1'b0);
		add_sample(gen_pos[1], gen_pos[1] ^ gen_pos[0], 1'b0);
		add_tick(gen_time + 32'd7);
		set_min_delta(16'd200);
		add_tick(gen_time + 32'd1);

		// Random phases, each under its own threshold
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: md = 16'd0;
				1: md = 16'd1;
				2: md = 16'd2;
				3: md = 16'hFFFF;
				4: md = 16'($urandom_range(3, 12));
				5: md = 16'd0;
				6: md = 16'($urandom_range(0, 65535));
				default: md = 16'd3;
			endcase
			set_min_delta(md);
			for (int i = 0; i < PHASE_ITEMS; i++)
				add_random_item();
			if (ph == 2 || ph == 5)
				stall_req = 1'b1;
		end

		settle();
		if (errors == 0) begin
			$display("quadrature_rate_button_monitor_core_tb: PASS");
		end else begin
			$display("quadrature_rate_button_monitor_core_tb: FAIL");
		end
		$finish;
	end

endmodule
